// ===== rtl/core/cfa_phase_statistics_macros.svh =====
// assertion helpers for the statistics block
`ifndef CFA_PHASE_STATISTICS_MACROS_SVH
`define CFA_PHASE_STATISTICS_MACROS_SVH

`define CFAPS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cfaps assertion failed");

`define CFAPS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("cfaps assertion failed");

`endif

// ===== rtl/core/cfaps_pkg.sv =====
package cfaps_pkg;

    localparam int COORD_BITS  = 14;
    localparam int SAMPLE_BITS = 16;
    localparam int NUM_PHASES  = 4;
    localparam int PH_BITS     = 2;
    localparam int CNT_BITS    = 28;
    localparam int SUM_BITS    = 44;
    localparam int MEAN_BITS   = 24;
    localparam int SPLIT_BITS  = 17;
    localparam int DVD_BITS    = 53;
    localparam int DVS_BITS    = 28;
    localparam int CFG_BITS    = 16;
    localparam int IDX_BITS    = 3;

    localparam logic [IDX_BITS-1:0] REG_TOP_OFFSET  = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_LEFT_OFFSET = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_ACTIVE_COLS = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_ACTIVE_ROWS = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_FRAME_COLS  = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_FRAME_ROWS  = 3'd5;
    localparam logic [IDX_BITS-1:0] REG_WHITE_LEVEL = 3'd6;

    localparam logic [15:0] SPLIT_SCALE = 16'd51200;

    typedef struct packed {
        logic [CNT_BITS-1:0]    cnt;
        logic [CNT_BITS-1:0]    clip;
        logic [SAMPLE_BITS-1:0] mn;
        logic [SAMPLE_BITS-1:0] mx;
        logic [SUM_BITS-1:0]    sum;
    } acc_t;

    localparam acc_t ACC_CLEAR = '{cnt: '0, clip: '0, mn: '1, mx: '0, sum: '0};

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD,
        S_MRD,
        S_MDIV,
        S_MWAIT,
        S_SMUL,
        S_SDIV,
        S_SWAIT,
        S_ERD,
        S_ELOAD,
        S_EHOLD
    } state_t;

endpackage

// ===== rtl/core/cfaps_div.sv =====
module cfaps_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [cfaps_pkg::DVD_BITS-1:0] dividend,
    input  logic [cfaps_pkg::DVS_BITS-1:0] divisor,
    output logic                           done,
    output logic [cfaps_pkg::DVD_BITS-1:0] quotient
);
    import cfaps_pkg::*;

    localparam int CW = $clog2(DVD_BITS + 1);

    logic [DVD_BITS-1:0] dvd_reg;
    logic [DVS_BITS:0]   rem_reg;
    logic [DVS_BITS-1:0] dvs_reg;
    logic [CW-1:0]       cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [DVS_BITS:0]   rem_sh;
    logic [DVS_BITS+1:0] diff;

    assign rem_sh = {rem_reg[DVS_BITS-1:0], dvd_reg[DVD_BITS-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DVD_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!diff[DVS_BITS+1])
            begin
                rem_reg <= diff[DVS_BITS:0];
                dvd_reg <= {dvd_reg[DVD_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                dvd_reg <= {dvd_reg[DVD_BITS-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// ===== rtl/core/cfa_phase_statistics.sv =====
// Per-phase raw frame statistics. A sample is taken when in_valid is high and
// in_stall low; each sample is handled in two steps, one to read its phase's accumulator
// entry from the memory and one to write the updated entry back. The sample that
// carries end_of_frame starts the frame-end pass: four means and one green split
// are worked out on a shared 53-step serial divider (a phase with no samples skips
// its division), then the four rows go out on the output channel, phase 0 first,
// each held until it is taken, and the accumulators read as cleared for the next
// frame. Samples are not taken during the frame-end pass.
// Registers may be written only while the block is idle.
module cfa_phase_statistics (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [cfaps_pkg::IDX_BITS-1:0]       cfg_index,
    input  logic [cfaps_pkg::CFG_BITS-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [cfaps_pkg::COORD_BITS-1:0]     pos_x,
    input  logic [cfaps_pkg::COORD_BITS-1:0]     pos_y,
    input  logic [cfaps_pkg::SAMPLE_BITS-1:0]    sample_value,
    input  logic [2:0]                           phase_index,
    input  logic                                 end_of_frame,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           phase,
    output logic [cfaps_pkg::CNT_BITS-1:0]       sample_count,
    output logic [cfaps_pkg::CNT_BITS-1:0]       clipped_count,
    output logic [cfaps_pkg::SAMPLE_BITS-1:0]    min_value,
    output logic [cfaps_pkg::SAMPLE_BITS-1:0]    max_value,
    output logic [cfaps_pkg::SUM_BITS-1:0]       value_sum,
    output logic [cfaps_pkg::MEAN_BITS-1:0]      mean_fixed,
    output logic signed [cfaps_pkg::SPLIT_BITS-1:0] green_split,
    output logic                                 green_split_valid,
    output logic                                 last_row
);
    import cfaps_pkg::*;

    logic [13:0] top_reg, left_reg;
    logic [14:0] acols_reg, arows_reg, fcols_reg, frows_reg;
    logic [15:0] white_reg;

    state_t state_reg, state_next;

    acc_t                  mem [NUM_PHASES];
    acc_t                  rd_q;
    logic                  rd_vld_q;
    logic [NUM_PHASES-1:0] vld_reg;
    logic [PH_BITS-1:0]    rd_addr;
    logic                  mem_we;
    acc_t                  wr_data;
    acc_t                  entry;

    logic                   keep_reg, eof_reg;
    logic [PH_BITS-1:0]     ph_reg;
    logic [SAMPLE_BITS-1:0] v_reg;
    logic [PH_BITS-1:0]     p_reg;

    logic [MEAN_BITS-1:0]   mean_reg [NUM_PHASES];
    logic [NUM_PHASES-1:0]  nz_reg;
    logic [40:0]            prod_reg;
    logic [24:0]            tot_reg;
    logic                   neg_reg;
    logic [SPLIT_BITS-1:0]  split_reg;
    logic                   svalid_reg;
    logic                   ov_reg;

    logic                   div_start, div_done;
    logic [DVD_BITS-1:0]    div_dvd, div_q;
    logic [DVS_BITS-1:0]    div_dvs;

    logic                   in_acc, out_acc, keep_in, win_x, win_y;
    logic [13:0]            dx, dy;
    logic [15:0]            white;
    logic [SUM_BITS:0]      sum_add;
    logic [MEAN_BITS-1:0]   mean_sat;
    logic [MEAN_BITS-1:0]   m1, m3;
    logic [MEAN_BITS-1:0]   mdiff;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = ov_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg   <= '0;
            left_reg  <= '0;
            acols_reg <= '0;
            arows_reg <= '0;
            fcols_reg <= '0;
            frows_reg <= '0;
            white_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TOP_OFFSET:  top_reg   <= cfg_data[13:0];
                REG_LEFT_OFFSET: left_reg  <= cfg_data[13:0];
                REG_ACTIVE_COLS: acols_reg <= cfg_data[14:0];
                REG_ACTIVE_ROWS: arows_reg <= cfg_data[14:0];
                REG_FRAME_COLS:  fcols_reg <= cfg_data[14:0];
                REG_FRAME_ROWS:  frows_reg <= cfg_data[14:0];
                REG_WHITE_LEVEL: white_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign dx      = pos_x - left_reg;
    assign dy      = pos_y - top_reg;
    assign win_x   = (pos_x >= left_reg) && ({1'b0, dx} < acols_reg)
                     && ({1'b0, pos_x} < fcols_reg);
    assign win_y   = (pos_y >= top_reg) && ({1'b0, dy} < arows_reg)
                     && ({1'b0, pos_y} < frows_reg);
    assign keep_in = !phase_index[2] && win_x && win_y;

    // accumulator memory, entries without a valid bit read as cleared
    assign rd_addr = (state_reg == S_IDLE) ? phase_index[PH_BITS-1:0] : p_reg;

    always_ff @(posedge clk)
    begin
        rd_q <= mem[rd_addr];
        if (mem_we)
        begin
            mem[ph_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rd_vld_q <= 1'b0;
        end
        else
        begin
            rd_vld_q <= vld_reg[rd_addr];
            if (mem_we)
            begin
                vld_reg[ph_reg] <= 1'b1;
            end
            else if (state_reg == S_EHOLD && out_acc && p_reg == PH_BITS'(NUM_PHASES - 1))
            begin
                vld_reg <= '0;
            end
        end
    end

    assign entry = rd_vld_q ? rd_q : ACC_CLEAR;

    assign white   = (white_reg == '0) ? '1 : white_reg;
    assign sum_add = {1'b0, entry.sum} + {{(SUM_BITS + 1 - SAMPLE_BITS){1'b0}}, v_reg};

    always_comb
    begin
        wr_data     = entry;
        wr_data.cnt = (entry.cnt == '1) ? entry.cnt : entry.cnt + 1'b1;
        if (v_reg >= white && entry.clip != '1)
        begin
            wr_data.clip = entry.clip + 1'b1;
        end
        if (v_reg < entry.mn)
        begin
            wr_data.mn = v_reg;
        end
        if (v_reg > entry.mx)
        begin
            wr_data.mx = v_reg;
        end
        wr_data.sum = sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_acc) state_next = S_UPD;
            S_UPD:   state_next = eof_reg ? S_MRD : S_IDLE;
            S_MRD:   state_next = S_MDIV;
            S_MDIV:  state_next = (entry.cnt == '0) ?
                                  ((p_reg == PH_BITS'(NUM_PHASES - 1)) ? S_SMUL : S_MRD) :
                                  S_MWAIT;
            S_MWAIT: if (div_done)
                         state_next = (p_reg == PH_BITS'(NUM_PHASES - 1)) ? S_SMUL : S_MRD;
            S_SMUL:  state_next = S_SDIV;
            S_SDIV:  state_next = S_SWAIT;
            S_SWAIT: if (div_done) state_next = S_ERD;
            S_ERD:   state_next = S_ELOAD;
            S_ELOAD: state_next = S_EHOLD;
            S_EHOLD: if (out_acc)
                         state_next = (p_reg == PH_BITS'(NUM_PHASES - 1)) ? S_IDLE : S_ERD;
            default: state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall  = 1'b1;
        mem_we    = 1'b0;
        div_start = 1'b0;
        div_dvd   = {entry.sum, 8'd0} + {{(DVD_BITS - CNT_BITS + 1){1'b0}},
                                         entry.cnt[CNT_BITS-1:1]};
        div_dvs   = entry.cnt;
        unique case (state_reg)
            S_IDLE:  in_stall = 1'b0;
            S_UPD:   mem_we = keep_reg;
            S_MDIV:  div_start = (entry.cnt != '0);
            S_SDIV:
            begin
                div_start = 1'b1;
                div_dvd   = {{(DVD_BITS - 41){1'b0}}, prod_reg};
                div_dvs   = {{(DVS_BITS - 25){1'b0}}, tot_reg};
            end
            default: ;
        endcase
    end

    cfaps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    assign mean_sat = (div_q[DVD_BITS-1:MEAN_BITS] != '0) ? '1 : div_q[MEAN_BITS-1:0];
    assign m1       = mean_reg[1];
    assign m3       = mean_reg[3];
    assign mdiff    = (m1 >= m3) ? m1 - m3 : m3 - m1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            p_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_UPD)
            begin
                p_reg <= '0;
            end
            else if ((state_reg == S_MDIV && entry.cnt == '0)
                     || (state_reg == S_MWAIT && div_done)
                     || (state_reg == S_EHOLD && out_acc))
            begin
                p_reg <= p_reg + 1'b1;
            end
            if (state_reg == S_ELOAD)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_acc)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            keep_reg <= keep_in;
            eof_reg  <= end_of_frame;
            ph_reg   <= phase_index[PH_BITS-1:0];
            v_reg    <= sample_value;
        end
        if (state_reg == S_MDIV)
        begin
            nz_reg[p_reg] <= (entry.cnt != '0);
            if (entry.cnt == '0)
            begin
                mean_reg[p_reg] <= '0;
            end
        end
        if (state_reg == S_MWAIT && div_done)
        begin
            mean_reg[p_reg] <= mean_sat;
        end
        if (state_reg == S_SMUL)
        begin
            prod_reg   <= 41'(mdiff) * 41'(SPLIT_SCALE)
                          + 41'(({1'b0, m1} + {1'b0, m3}) >> 1);
            tot_reg    <= {1'b0, m1} + {1'b0, m3};
            neg_reg    <= (m1 < m3);
            svalid_reg <= nz_reg[1] && nz_reg[3] && ({1'b0, m1} + {1'b0, m3} != '0);
        end
        if (state_reg == S_SWAIT && div_done)
        begin
            if (!svalid_reg)
            begin
                split_reg <= '0;
            end
            else if (neg_reg)
            begin
                split_reg <= '0 - div_q[SPLIT_BITS-1:0];
            end
            else
            begin
                split_reg <= div_q[SPLIT_BITS-1:0];
            end
        end
        if (state_reg == S_ELOAD)
        begin
            phase             <= p_reg;
            sample_count      <= entry.cnt;
            clipped_count     <= entry.clip;
            min_value         <= (entry.cnt != '0) ? entry.mn : '0;
            max_value         <= entry.mx;
            value_sum         <= entry.sum;
            mean_fixed        <= mean_reg[p_reg];
            green_split       <= split_reg;
            green_split_valid <= svalid_reg;
            last_row          <= (p_reg == PH_BITS'(NUM_PHASES - 1));
        end
    end

    assign out_valid = ov_reg;

endmodule

// ===== rtl/core/cfaps_checker.sv =====
module cfaps_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 cfg_we,
    input logic [cfaps_pkg::IDX_BITS-1:0]       cfg_index,
    input logic [cfaps_pkg::CFG_BITS-1:0]       cfg_data,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic [cfaps_pkg::COORD_BITS-1:0]     pos_x,
    input logic [cfaps_pkg::COORD_BITS-1:0]     pos_y,
    input logic [cfaps_pkg::SAMPLE_BITS-1:0]    sample_value,
    input logic [2:0]                           phase_index,
    input logic                                 end_of_frame,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic [1:0]                           phase,
    input logic [cfaps_pkg::CNT_BITS-1:0]       sample_count,
    input logic [cfaps_pkg::CNT_BITS-1:0]       clipped_count,
    input logic [cfaps_pkg::SAMPLE_BITS-1:0]    min_value,
    input logic [cfaps_pkg::SAMPLE_BITS-1:0]    max_value,
    input logic [cfaps_pkg::SUM_BITS-1:0]       value_sum,
    input logic [cfaps_pkg::MEAN_BITS-1:0]      mean_fixed,
    input logic signed [cfaps_pkg::SPLIT_BITS-1:0] green_split,
    input logic                                 green_split_valid,
    input logic                                 last_row
);
    `include "cfa_phase_statistics_macros.svh"

    // no sample is taken while frame-end rows are pending
    `CFAPS_ASSERT(a_rows_block_input, out_valid |-> in_stall)
    `CFAPS_ASSERT(a_last_is_phase3, out_valid && last_row |-> phase == 2'd3)
    `CFAPS_ASSERT(a_split_zero, out_valid && !green_split_valid |-> green_split == '0)
    `CFAPS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(phase))
    `CFAPS_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid)

endmodule

bind cfa_phase_statistics cfaps_checker u_cfaps_checker (.*);
